/* hw/rtl/sao_eo_pkg.sv */
// ----------------------------------------------------------------------------
// sao_eo_pkg
// Shared types and constants for the horizontal SAO edge-offset filter.
// ----------------------------------------------------------------------------
package sao_eo_pkg;

    // Offset registers are 10-bit two's complement
    localparam int OFF_W     = 10;
    localparam int NUM_CLASS = 5;

    // Configuration port geometry (eight 32-bit registers)
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int DEPTH_W   = 4;

    typedef logic signed [OFF_W-1:0] offset_t;

    // Register map, index = byte address / 4
    typedef enum logic [2:0] {
        REG_PEL_DEPTH  = 3'd0,
        REG_LEFT_AVAIL = 3'd1,
        REG_RIGHT_AVAIL = 3'd2,
        REG_OFFSET0    = 3'd3,
        REG_OFFSET1    = 3'd4,
        REG_OFFSET2    = 3'd5,
        REG_OFFSET3    = 3'd6,
        REG_OFFSET4    = 3'd7
    } reg_idx_t;

    // Edge class codes
    localparam logic [2:0] CLASS_MIN  = 3'd0;
    localparam logic [2:0] CLASS_C1   = 3'd1;
    localparam logic [2:0] CLASS_FLAT = 3'd2;
    localparam logic [2:0] CLASS_C3   = 3'd3;
    localparam logic [2:0] CLASS_MAX  = 3'd4;

    // Position of the window within a row
    typedef enum logic [3:0] {
        POS_LEFT     = 4'b0001,  // awaiting the left neighbour
        POS_AWAIT_C0 = 4'b0010,  // awaiting column 0
        POS_COL0     = 4'b0100,  // centre is column 0
        POS_LATER    = 4'b1000   // centre is a later column
    } pos_t;

    // Configuration bundle
    typedef struct packed {
        logic [DEPTH_W-1:0]           pel_depth;
        logic                         left_available;
        logic                         right_available;
        offset_t [NUM_CLASS-1:0]      offset;
    } cfg_t;

    // Control from the window stage to the filter stage
    typedef struct packed {
        logic fire;   // staged word consumed this cycle
        logic emit;   // and it produces a result
        logic first;  // centre is column 0
        logic last;   // centre is the row's last pixel
    } win_ctl_t;

endpackage

/* hw/rtl/sao_eo_regs.sv */
// ----------------------------------------------------------------------------
// sao_eo_regs
// APB register file: bit depth, side availability and five class offsets.
// ----------------------------------------------------------------------------
module sao_eo_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sao_eo_pkg::ADDR_W-1:0]    paddr,
    input  logic [sao_eo_pkg::DATA_W-1:0]    pwdata,
    output logic [sao_eo_pkg::DATA_W-1:0]    prdata,
    output logic                             pready,
    output sao_eo_pkg::cfg_t                 cfg
);

    sao_eo_pkg::cfg_t      cfg_reg;
    sao_eo_pkg::reg_idx_t  idx;
    logic                  wr_en;

    assign pready = 1'b1;
    assign idx    = sao_eo_pkg::reg_idx_t'(paddr[sao_eo_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pel_depth       <= sao_eo_pkg::DEPTH_W'(8);
            cfg_reg.left_available  <= 1'b1;
            cfg_reg.right_available <= 1'b1;
            cfg_reg.offset          <= '0;
        end else if (wr_en) begin
            unique case (idx)
                sao_eo_pkg::REG_PEL_DEPTH:
                    cfg_reg.pel_depth <= pwdata[sao_eo_pkg::DEPTH_W-1:0];
                sao_eo_pkg::REG_LEFT_AVAIL:  cfg_reg.left_available  <= pwdata[0];
                sao_eo_pkg::REG_RIGHT_AVAIL: cfg_reg.right_available <= pwdata[0];
                sao_eo_pkg::REG_OFFSET0: cfg_reg.offset[0] <= pwdata[sao_eo_pkg::OFF_W-1:0];
                sao_eo_pkg::REG_OFFSET1: cfg_reg.offset[1] <= pwdata[sao_eo_pkg::OFF_W-1:0];
                sao_eo_pkg::REG_OFFSET2: cfg_reg.offset[2] <= pwdata[sao_eo_pkg::OFF_W-1:0];
                sao_eo_pkg::REG_OFFSET3: cfg_reg.offset[3] <= pwdata[sao_eo_pkg::OFF_W-1:0];
                sao_eo_pkg::REG_OFFSET4: cfg_reg.offset[4] <= pwdata[sao_eo_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (idx)
            sao_eo_pkg::REG_PEL_DEPTH:
                prdata = sao_eo_pkg::DATA_W'(cfg_reg.pel_depth);
            sao_eo_pkg::REG_LEFT_AVAIL:
                prdata = sao_eo_pkg::DATA_W'(cfg_reg.left_available);
            sao_eo_pkg::REG_RIGHT_AVAIL:
                prdata = sao_eo_pkg::DATA_W'(cfg_reg.right_available);
            sao_eo_pkg::REG_OFFSET0:
                prdata = sao_eo_pkg::DATA_W'(unsigned'(cfg_reg.offset[0]));
            sao_eo_pkg::REG_OFFSET1:
                prdata = sao_eo_pkg::DATA_W'(unsigned'(cfg_reg.offset[1]));
            sao_eo_pkg::REG_OFFSET2:
                prdata = sao_eo_pkg::DATA_W'(unsigned'(cfg_reg.offset[2]));
            sao_eo_pkg::REG_OFFSET3:
                prdata = sao_eo_pkg::DATA_W'(unsigned'(cfg_reg.offset[3]));
            sao_eo_pkg::REG_OFFSET4:
                prdata = sao_eo_pkg::DATA_W'(unsigned'(cfg_reg.offset[4]));
            default: prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/sao_eo_window.sv */
// ----------------------------------------------------------------------------
// sao_eo_window
// Input register and three-pixel window with row position tracking.
// ----------------------------------------------------------------------------
module sao_eo_window #(
    parameter int PIXEL_WIDTH = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [PIXEL_WIDTH-1:0]      s_sample,
    input  logic                        s_row_end,
    input  logic                        out_free,
    output logic [PIXEL_WIDTH-1:0]      left_pix,
    output logic [PIXEL_WIDTH-1:0]      centre_pix,
    output logic [PIXEL_WIDTH-1:0]      right_pix,
    output sao_eo_pkg::win_ctl_t        ctl
);

    logic                      in_valid_reg;
    logic [PIXEL_WIDTH-1:0]    in_sample_reg;
    logic                      in_end_reg;
    logic [PIXEL_WIDTH-1:0]    left_reg;
    logic [PIXEL_WIDTH-1:0]    centre_reg;
    sao_eo_pkg::pos_t          pos_reg;
    sao_eo_pkg::pos_t          pos_next;
    logic                      fire;
    logic                      emit;

    // Staged word moves on when the result register can take it
    assign fire    = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || out_free;
    assign emit    = fire && (pos_reg == sao_eo_pkg::POS_COL0 ||
                              pos_reg == sao_eo_pkg::POS_LATER);

    assign left_pix   = left_reg;
    assign centre_pix = centre_reg;
    assign right_pix  = in_sample_reg;
    assign ctl.fire   = fire;
    assign ctl.emit   = emit;
    assign ctl.first  = (pos_reg == sao_eo_pkg::POS_COL0);
    assign ctl.last   = in_end_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
            in_end_reg    <= s_row_end;
        end
    end

    // Row position
    always_comb begin
        pos_next = pos_reg;
        unique case (pos_reg)
            sao_eo_pkg::POS_LEFT:
                pos_next = in_end_reg ? sao_eo_pkg::POS_LEFT : sao_eo_pkg::POS_AWAIT_C0;
            sao_eo_pkg::POS_AWAIT_C0:
                pos_next = in_end_reg ? sao_eo_pkg::POS_LEFT : sao_eo_pkg::POS_COL0;
            sao_eo_pkg::POS_COL0, sao_eo_pkg::POS_LATER:
                pos_next = in_end_reg ? sao_eo_pkg::POS_LEFT : sao_eo_pkg::POS_LATER;
            default: pos_next = sao_eo_pkg::POS_LEFT;
        endcase
    end

    // Window shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= sao_eo_pkg::POS_LEFT;
            left_reg   <= '0;
            centre_reg <= '0;
        end else if (fire) begin
            pos_reg <= pos_next;
            if (pos_reg == sao_eo_pkg::POS_LEFT) begin
                left_reg <= in_sample_reg;
            end else if (pos_reg == sao_eo_pkg::POS_AWAIT_C0) begin
                centre_reg <= in_sample_reg;
            end else if (!in_end_reg) begin
                left_reg   <= centre_reg;
                centre_reg <= in_sample_reg;
            end
        end
    end

    // A row end always brings the window back to the row start
    a_row_end_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_end_reg) |=> (pos_reg == sao_eo_pkg::POS_LEFT))
        else $error("window did not restart after row end");

    // Window holds while the staged word waits
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> ($stable(left_reg) && $stable(centre_reg)
                                         && $stable(pos_reg)))
        else $error("window moved during stall");

    // Results only leave with a fully formed window
    a_emit_needs_centre: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && pos_reg == sao_eo_pkg::POS_AWAIT_C0 && !in_end_reg)
        |=> (centre_reg == $past(in_sample_reg)))
        else $error("column 0 not loaded into centre");

endmodule

/* hw/rtl/sao_eo_filter.sv */
// ----------------------------------------------------------------------------
// sao_eo_filter
// Edge classification, offset add, clip, and the result register.
// ----------------------------------------------------------------------------
module sao_eo_filter #(
    parameter int PIXEL_WIDTH = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sao_eo_pkg::cfg_t            cfg,
    input  logic [PIXEL_WIDTH-1:0]      left_pix,
    input  logic [PIXEL_WIDTH-1:0]      centre_pix,
    input  logic [PIXEL_WIDTH-1:0]      right_pix,
    input  sao_eo_pkg::win_ctl_t        ctl,
    output logic                        out_free,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [PIXEL_WIDTH-1:0]      m_filtered,
    output logic [2:0]                  m_edge_class,
    output logic                        m_row_last
);

    localparam int DW  = $clog2(PIXEL_WIDTH + 1);
    localparam int PW1 = PIXEL_WIDTH + 1;
    localparam int SW  = ((PIXEL_WIDTH > sao_eo_pkg::OFF_W) ?
                          PIXEL_WIDTH : sao_eo_pkg::OFF_W) + 2;

    logic                      valid_reg;
    logic [PIXEL_WIDTH-1:0]    filtered_reg;
    logic [2:0]                class_reg;
    logic                      last_reg;

    logic                      gt_l, lt_l, gt_r, lt_r;
    logic [2:0]                cls;
    sao_eo_pkg::offset_t       off;
    logic [DW-1:0]             depth;
    logic [PW1-1:0]            maxpel;
    logic signed [SW-1:0]      sum;
    logic [PIXEL_WIDTH-1:0]    clipped;
    logic                      bypass;
    logic [PIXEL_WIDTH-1:0]    result;

    // Edge class from the two neighbour signs
    always_comb begin
        gt_l = centre_pix > left_pix;
        lt_l = centre_pix < left_pix;
        gt_r = centre_pix > right_pix;
        lt_r = centre_pix < right_pix;
        cls  = sao_eo_pkg::CLASS_FLAT + {2'b00, gt_l} + {2'b00, gt_r}
               - {2'b00, lt_l} - {2'b00, lt_r};
    end

    // Offset select
    always_comb begin
        case (cls)
            sao_eo_pkg::CLASS_MIN:  off = cfg.offset[0];
            sao_eo_pkg::CLASS_C1:   off = cfg.offset[1];
            sao_eo_pkg::CLASS_FLAT: off = cfg.offset[2];
            sao_eo_pkg::CLASS_C3:   off = cfg.offset[3];
            sao_eo_pkg::CLASS_MAX:  off = cfg.offset[4];
            default:                off = cfg.offset[2];
        endcase
    end

    // Add and clip to 0 .. 2^depth - 1 (depth capped at PIXEL_WIDTH); bypass on unavailable sides
    always_comb begin
        if ({1'b0, cfg.pel_depth} > (sao_eo_pkg::DEPTH_W + 1)'(PIXEL_WIDTH)) begin
            depth = DW'(PIXEL_WIDTH);
        end else begin
            depth = DW'(cfg.pel_depth);
        end
        maxpel = (PW1'(1) << depth) - PW1'(1);
        sum    = $signed(SW'(centre_pix)) + SW'(off);
        if (sum[SW-1]) begin
            clipped = '0;
        end else if (sum > $signed(SW'(maxpel))) begin
            clipped = maxpel[PIXEL_WIDTH-1:0];
        end else begin
            clipped = sum[PIXEL_WIDTH-1:0];
        end
        bypass = (ctl.first && !cfg.left_available) ||
                 (ctl.last && !cfg.right_available);
        result = bypass ? centre_pix : clipped;
    end

    // Result register
    assign out_free     = !valid_reg || m_ready;
    assign m_valid      = valid_reg;
    assign m_filtered   = filtered_reg;
    assign m_edge_class = class_reg;
    assign m_row_last   = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.emit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            filtered_reg <= result;
            class_reg    <= cls;
            last_reg     <= ctl.last;
        end
    end

    // Reported class stays within the five defined codes
    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (class_reg <= sao_eo_pkg::CLASS_MAX))
        else $error("edge class out of range");

    // A result is only loaded when the register is free to take it
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit |-> out_free)
        else $error("result register overwritten");

    // A flat neighbourhood always yields the flat class
    a_flat_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.emit && centre_pix == left_pix && centre_pix == right_pix)
        |=> (class_reg == sao_eo_pkg::CLASS_FLAT))
        else $error("flat window misclassified");

endmodule

/* hw/rtl/sao_edge_offset_horizontal.sv */
// A staged word's result (if any) reaches m_* through the result register.
// Throughput: one word per cycle unless m_ready stalls the input and result registers.
// Each row of w pixels takes w+2 words and yields w results.
// Reset (aresetn low, synchronous): both stages empty, window at row start,
// bit depth 8, both sides available, all offsets zero.
// ----------------------------------------------------------------------------
// sao_edge_offset_horizontal
// Horizontal SAO edge-offset filter over a stream of padded pixel rows.
// ----------------------------------------------------------------------------
module sao_edge_offset_horizontal #(
    parameter int PIXEL_WIDTH = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sao_eo_pkg::ADDR_W-1:0]    paddr,
    input  logic [sao_eo_pkg::DATA_W-1:0]    pwdata,
    output logic [sao_eo_pkg::DATA_W-1:0]    prdata,
    output logic                             pready,
    // Pixel input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [PIXEL_WIDTH-1:0]           s_sample,
    input  logic                             s_row_end,
    // Filtered output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [PIXEL_WIDTH-1:0]           m_filtered,
    output logic [2:0]                       m_edge_class,
    output logic                             m_row_last
);

    sao_eo_pkg::cfg_t        cfg;
    sao_eo_pkg::win_ctl_t    ctl;
    logic [PIXEL_WIDTH-1:0]  left_pix;
    logic [PIXEL_WIDTH-1:0]  centre_pix;
    logic [PIXEL_WIDTH-1:0]  right_pix;
    logic                    out_free;

    // Register file
    sao_eo_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input stage and window
    sao_eo_window #(
        .PIXEL_WIDTH (PIXEL_WIDTH)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .s_row_end  (s_row_end),
        .out_free   (out_free),
        .left_pix   (left_pix),
        .centre_pix (centre_pix),
        .right_pix  (right_pix),
        .ctl        (ctl)
    );

    // Classify, offset, clip, result register
    sao_eo_filter #(
        .PIXEL_WIDTH (PIXEL_WIDTH)
    ) u_filter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .left_pix     (left_pix),
        .centre_pix   (centre_pix),
        .right_pix    (right_pix),
        .ctl          (ctl),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_filtered   (m_filtered),
        .m_edge_class (m_edge_class),
        .m_row_last   (m_row_last)
    );

endmodule

/* tb/tb_sao_edge_offset_horizontal.sv */
// ----------------------------------------------------------------------------
// tb_sao_edge_offset_horizontal
// Self-checking bench for the horizontal SAO edge-offset filter. A local
// window model predicts each filtered word as input words are accepted, and
// a result monitor compares every output word against the oldest prediction.
// Directed rows cover every edge class, clipping, short rows and the
// unavailable-side pass-through. Random rows then run under several register
// settings with random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_sao_edge_offset_horizontal;

    localparam int PW           = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [PW-1:0] filtered;
        logic [2:0]    edge_class;
        logic          row_last;
    } px_result_t;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                psel      = 1'b0;
    logic                                penable   = 1'b0;
    logic                                pwrite    = 1'b0;
    logic [sao_eo_pkg::ADDR_W-1:0]       paddr     = '0;
    logic [sao_eo_pkg::DATA_W-1:0]       pwdata    = '0;
    logic [sao_eo_pkg::DATA_W-1:0]       prdata;
    logic                                pready;
    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    logic [PW-1:0]                       s_sample  = '0;
    logic                                s_row_end = 1'b0;
    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    logic [PW-1:0]                       m_filtered;
    logic [2:0]                          m_edge_class;
    logic                                m_row_last;

    // Window model state and register shadow
    logic [PW-1:0]                       win_left;
    logic [PW-1:0]                       win_centre;
    sao_eo_pkg::pos_t                    win_pos;
    logic [sao_eo_pkg::DEPTH_W-1:0]      cfg_depth;
    logic                                cfg_left_avail;
    logic                                cfg_right_avail;
    sao_eo_pkg::offset_t                 cfg_offset [sao_eo_pkg::NUM_CLASS];

    px_result_t          expected_px [$];
    int                  fail_count    = 0;
    int                  words_sent    = 0;
    int                  cycle_count   = 0;
    bit                  src_idle_en   = 1'b1;
    bit                  sink_idle_en  = 1'b1;
    bit                  sink_hold_req = 1'b0;

    sao_edge_offset_horizontal #(.PIXEL_WIDTH(PW)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_row_end    (s_row_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_filtered   (m_filtered),
        .m_edge_class (m_edge_class),
        .m_row_last   (m_row_last)
    );

    always #5 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Window model
    // ------------------------------------------------------------------
    function automatic void reset_model();
        win_left        = '0;
        win_centre      = '0;
        win_pos         = sao_eo_pkg::POS_LEFT;
        cfg_depth       = sao_eo_pkg::DEPTH_W'(8);
        cfg_left_avail  = 1'b1;
        cfg_right_avail = 1'b1;
        for (int k = 0; k < sao_eo_pkg::NUM_CLASS; k++) cfg_offset[k] = '0;
    endfunction

    function automatic int diff_sign(input logic [PW-1:0] a, input logic [PW-1:0] b);
        if (a > b) return 1;
        if (a < b) return -1;
        return 0;
    endfunction

    function automatic void apply_config(input sao_eo_pkg::reg_idx_t idx,
                                         input logic [sao_eo_pkg::DATA_W-1:0] data);
        case (idx)
            sao_eo_pkg::REG_PEL_DEPTH:   cfg_depth       = data[sao_eo_pkg::DEPTH_W-1:0];
            sao_eo_pkg::REG_LEFT_AVAIL:  cfg_left_avail  = data[0];
            sao_eo_pkg::REG_RIGHT_AVAIL: cfg_right_avail = data[0];
            default:
                cfg_offset[int'(idx) - int'(sao_eo_pkg::REG_OFFSET0)] =
                    data[sao_eo_pkg::OFF_W-1:0];
        endcase
    endfunction

    // Advance the window by one accepted word; queue the result it produces
    function automatic void predict_filter(input logic [PW-1:0] smp, input logic rend);
        px_result_t r;
        logic       col0;
        int         cls;
        int         depth;
        int         maxpel;
        int         sum;
        case (win_pos)
            sao_eo_pkg::POS_LEFT: begin
                win_left = smp;
                win_pos  = rend ? sao_eo_pkg::POS_LEFT : sao_eo_pkg::POS_AWAIT_C0;
            end
            sao_eo_pkg::POS_AWAIT_C0: begin
                win_centre = smp;
                win_pos    = rend ? sao_eo_pkg::POS_LEFT : sao_eo_pkg::POS_COL0;
            end
            default: begin
                col0   = (win_pos == sao_eo_pkg::POS_COL0);
                cls    = 2 + diff_sign(win_centre, win_left) + diff_sign(win_centre, smp);
                depth  = (int'(cfg_depth) > PW) ? PW : int'(cfg_depth);
                maxpel = (1 << depth) - 1;
                if ((col0 && !cfg_left_avail) || (rend && !cfg_right_avail)) begin
                    r.filtered = win_centre;
                end else begin
                    sum = int'(win_centre) + int'(cfg_offset[cls]);
                    if (sum < 0) sum = 0;
                    if (sum > maxpel) sum = maxpel;
                    r.filtered = PW'(sum);
                end
                r.edge_class = 3'(cls);
                r.row_last   = rend;
                expected_px.push_back(r);
                if (rend) begin
                    win_pos = sao_eo_pkg::POS_LEFT;
                end else begin
                    win_left   = win_centre;
                    win_centre = smp;
                    win_pos    = sao_eo_pkg::POS_LATER;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        px_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_px.size() == 0) begin
                $error("unexpected result word: filtered=%0d edge_class=%0d row_last=%0d",
                       m_filtered, m_edge_class, m_row_last);
                fail_count++;
            end else begin
                exp_r = expected_px.pop_front();
                if (m_filtered !== exp_r.filtered) begin
                    $error("filtered: expected %0d, got %0d", exp_r.filtered, m_filtered);
                    fail_count++;
                end
                if (m_edge_class !== exp_r.edge_class) begin
                    $error("edge_class: expected %0d, got %0d", exp_r.edge_class, m_edge_class);
                    fail_count++;
                end
                if (m_row_last !== exp_r.row_last) begin
                    $error("row_last: expected %0d, got %0d", exp_r.row_last, m_row_last);
                    fail_count++;
                end
            end
        end
    end

    // Output-side ready: random stall per word, or one long hold on request
    initial begin : result_sink
        int hold;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_req) begin
                hold          = HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end else begin
                hold = sink_idle_en ? $urandom_range(0, 9) : 0;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_word(input logic [PW-1:0] smp, input logic rend);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_sample  <= smp;
        s_row_end <= rend;
        do @(posedge aclk); while (!s_ready);
        predict_filter(smp, rend);
        words_sent++;
    endtask

    // Stop offering, let every pending result arrive, then let the pipe settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_px.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Setup then access phase; back-to-back writes keep psel high
    task automatic apb_write(input sao_eo_pkg::reg_idx_t idx,
                             input logic [sao_eo_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sao_eo_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        apply_config(idx, data);
    endtask

    task automatic apply_offset_write(input int k, input sao_eo_pkg::offset_t off);
        apb_write(sao_eo_pkg::reg_idx_t'(int'(sao_eo_pkg::REG_OFFSET0) + k),
                  {{(sao_eo_pkg::DATA_W-sao_eo_pkg::OFF_W){1'b0}}, off});
    endtask

    task automatic write_config(input logic [sao_eo_pkg::DEPTH_W-1:0] depth,
                                input logic left_av, input logic right_av,
                                input sao_eo_pkg::offset_t [sao_eo_pkg::NUM_CLASS-1:0] offs);
        wait_idle();
        apb_write(sao_eo_pkg::REG_PEL_DEPTH, sao_eo_pkg::DATA_W'(depth));
        apb_write(sao_eo_pkg::REG_LEFT_AVAIL, sao_eo_pkg::DATA_W'(left_av));
        apb_write(sao_eo_pkg::REG_RIGHT_AVAIL, sao_eo_pkg::DATA_W'(right_av));
        for (int k = 0; k < sao_eo_pkg::NUM_CLASS; k++)
            apply_offset_write(k, offs[k]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Mix of random, near-equal and near-clip values so all classes show up
    function automatic logic [PW-1:0] pick_sample(input logic [PW-1:0] prev);
        case ($urandom_range(0, 5))
            0, 1:    return PW'($urandom);
            2:       return PW'($urandom_range(0, 3));
            3:       return prev;
            4:       return PW'($urandom_range(250, 260));
            default: return PW'($urandom_range(1016, 1023));
        endcase
    endfunction

    // Left neighbour, width pixels, right neighbour flagged as row end
    task automatic send_row(input int width);
        logic [PW-1:0] smp;
        smp = PW'($urandom);
        send_word(smp, 1'b0);
        for (int i = 0; i <= width; i++) begin
            smp = pick_sample(smp);
            send_word(smp, i == width);
        end
    endtask

    function automatic sao_eo_pkg::offset_t pick_offset();
        case ($urandom_range(0, 7))
            0:       return sao_eo_pkg::offset_t'(-512);
            1:       return sao_eo_pkg::offset_t'(511);
            2:       return '0;
            3:       return sao_eo_pkg::offset_t'($urandom_range(0, 15))
                            - sao_eo_pkg::offset_t'(8);
            default: return sao_eo_pkg::offset_t'($urandom);
        endcase
    endfunction

    function automatic logic [sao_eo_pkg::DEPTH_W-1:0] pick_depth();
        case ($urandom_range(0, 5))
            0:       return sao_eo_pkg::DEPTH_W'(0);
            1:       return sao_eo_pkg::DEPTH_W'(8);
            2:       return sao_eo_pkg::DEPTH_W'(9);
            3:       return sao_eo_pkg::DEPTH_W'(10);
            4:       return sao_eo_pkg::DEPTH_W'(15);
            default: return sao_eo_pkg::DEPTH_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One row that hits every edge class and clips at zero
    task automatic test_edge_classes();
        sao_eo_pkg::offset_t [sao_eo_pkg::NUM_CLASS-1:0] offs;
        offs[0] = sao_eo_pkg::offset_t'(511);
        offs[1] = sao_eo_pkg::offset_t'(3);
        offs[2] = sao_eo_pkg::offset_t'(-1);
        offs[3] = sao_eo_pkg::offset_t'(-7);
        offs[4] = sao_eo_pkg::offset_t'(-512);
        write_config(sao_eo_pkg::DEPTH_W'(10), 1'b1, 1'b1, offs);
        send_word(PW'(0), 1'b0);
        send_word(PW'(10), 1'b0);
        send_word(PW'(5), 1'b0);
        send_word(PW'(10), 1'b0);
        send_word(PW'(10), 1'b0);
        send_word(PW'(20), 1'b0);
        send_word(PW'(20), 1'b0);
        send_word(PW'(30), 1'b0);
        send_word(PW'(1023), 1'b0);
        send_word(PW'(0), 1'b0);
        send_word(PW'(1023), 1'b1);
        wait_idle();
    endtask

    // Row end on the left neighbour, on column 0, then a one-pixel row
    task automatic test_short_rows();
        send_word(PW'(7), 1'b1);
        send_word(PW'(3), 1'b0);
        send_word(PW'(9), 1'b1);
        send_word(PW'(100), 1'b0);
        send_word(PW'(50), 1'b0);
        send_word(PW'(100), 1'b1);
        wait_idle();
    endtask

    // Unavailable sides pass raw pixels; depth 0 clips to zero, depth 15 acts as 10
    task automatic test_unavailable_sides();
        sao_eo_pkg::offset_t [sao_eo_pkg::NUM_CLASS-1:0] offs;
        for (int k = 0; k < sao_eo_pkg::NUM_CLASS; k++) offs[k] = sao_eo_pkg::offset_t'(-1);
        write_config(sao_eo_pkg::DEPTH_W'(0), 1'b0, 1'b0, offs);
        send_word(PW'(0), 1'b0);
        send_word(PW'(1023), 1'b0);
        send_word(PW'(600), 1'b0);
        send_word(PW'(300), 1'b0);
        send_word(PW'(1023), 1'b1);
        write_config(sao_eo_pkg::DEPTH_W'(15), 1'b1, 1'b1, offs);
        send_word(PW'(0), 1'b0);
        send_word(PW'(1000), 1'b0);
        send_word(PW'(1023), 1'b1);
        wait_idle();
    endtask

    // Output held off for a long stretch while input streams with no gaps
    task automatic test_backpressure();
        src_idle_en   = 1'b0;
        sink_hold_req = 1'b1;
        while (words_sent < 120) send_row($urandom_range(4, 16));
        wait_idle();
        src_idle_en = 1'b1;
    endtask

    // Random rows across several register settings and idle patterns
    task automatic test_random_rows();
        sao_eo_pkg::offset_t [sao_eo_pkg::NUM_CLASS-1:0] offs;
        int                                              target;
        int                                              pick;
        for (int phase = 0; phase < 8; phase++) begin
            for (int k = 0; k < sao_eo_pkg::NUM_CLASS; k++) offs[k] = pick_offset();
            if (phase == 0) begin
                for (int k = 0; k < sao_eo_pkg::NUM_CLASS; k++)
                    offs[k] = sao_eo_pkg::offset_t'(511);
                write_config(sao_eo_pkg::DEPTH_W'(10), 1'b1, 1'b0, offs);
            end else if (phase == 1) begin
                for (int k = 0; k < sao_eo_pkg::NUM_CLASS; k++)
                    offs[k] = sao_eo_pkg::offset_t'(-512);
                write_config(sao_eo_pkg::DEPTH_W'(8), 1'b0, 1'b1, offs);
            end else begin
                write_config(pick_depth(), 1'($urandom), 1'($urandom), offs);
            end
            src_idle_en  = (phase % 4) != 1;
            sink_idle_en = (phase % 4) != 2;
            target       = words_sent + 125;
            while (words_sent < target) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_word(PW'($urandom), 1'b1);
                end else if (pick == 1) begin
                    send_word(PW'($urandom), 1'b0);
                    send_word(PW'($urandom), 1'b1);
                end else if (pick == 2) begin
                    send_row($urandom_range(17, 40));
                end else begin
                    send_row($urandom_range(1, 16));
                end
            end
            wait_idle();
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edge_classes();
        test_short_rows();
        test_unavailable_sides();
        test_backpressure();
        test_random_rows();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_px.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/sao_eo_pkg.sv
hw/rtl/sao_eo_regs.sv
hw/rtl/sao_eo_window.sv
hw/rtl/sao_eo_filter.sv
hw/rtl/sao_edge_offset_horizontal.sv
tb/tb_sao_edge_offset_horizontal.sv
